// File: rtl/core/hlph_pkg.sv
// shared types and constants for the lattice pair histogram
package hlph_pkg;

   localparam int MAX_ATOMS_DEF     = 256;
   localparam int MAX_SIDE_DEF      = 64;
   localparam int HIST_BINS_DEF     = 8192;
   localparam int BINS_PER_UNIT_DEF = 100;

   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_ACCUM = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   localparam logic CSR_SIDE_LOG2  = 1'b0;
   localparam logic CSR_ATOM_COUNT = 1'b1;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [7:0]  atom_slot;
      logic [11:0] site_index;
      logic [12:0] bin_select;
   } req_type;

   typedef struct packed {
      logic [31:0] bin_count;
      logic        range_error;
      logic        saturated;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PAIR_RD,
      ST_PAIR_DIST,
      ST_MIN,
      ST_MUL,
      ST_SQRT,
      ST_HIST_RD,
      ST_HIST_WR,
      ST_READ_WAIT,
      ST_RESP
   } state_type;

endpackage

// File: rtl/core/hex_lattice_pair_histogram_top.sv
// pair distance histogram for atoms on a helically wrapped triangular lattice
//
// req channel (valid/ready) carries one command transaction: write atom site,
// accumulate over all ordered atom pairs, or read one histogram bin. every
// command returns exactly one transaction on the rsp channel (valid/ready).
// csr port writes lattice_side_log2 (index 0) and atom_count (index 1); the
// user must write it only while the block is idle, which is not enforced.
// after a site write is accepted the block enters its response state, then
// raises rsp_valid; a bin read first passes through a read-wait state.
// an accumulate pass walks each ordered pair through one shared datapath:
// site read, decode, image minimum over the direct distance and one or
// three periodic images (one candidate per cycle), multiply, a bit-serial
// square root of one root bit per cycle (16 steps plus a finishing step)
// and histogram read-modify-write, n*(n-1) pairs for n atoms.
// after reset the histogram memory is cleared one bin per cycle, while
// req_ready stays low. the result is held in an output register until
// rsp_ready; the block takes no new command while it waits.
module hex_lattice_pair_histogram_top
   import hlph_pkg::*;
#(
   parameter int MAX_ATOMS     = MAX_ATOMS_DEF,
   parameter int MAX_SIDE      = MAX_SIDE_DEF,
   parameter int HIST_BINS     = HIST_BINS_DEF,
   parameter int BINS_PER_UNIT = BINS_PER_UNIT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [8:0]  csr_write_data
);

   localparam int AW = (MAX_ATOMS > 2) ? $clog2(MAX_ATOMS) : 1;
   localparam int CW = $clog2(MAX_ATOMS + 1);
   localparam int HW = $clog2(HIST_BINS);
   localparam int SLW = $clog2(MAX_SIDE);
   localparam int SW = 2 * SLW;
   localparam logic [63:0] K2 = 64'(BINS_PER_UNIT) * 64'(BINS_PER_UNIT);
   localparam int KW = $clog2(BINS_PER_UNIT * BINS_PER_UNIT + 1);
   // distance square fits 2*SLW+5 bits comfortably
   localparam int DW = 2 * SLW + 6;
   localparam int PW_RAW = DW + KW;
   localparam int PW = PW_RAW + (PW_RAW % 2);
   localparam int RW = PW / 2 + 1;

   // storage
   logic [11:0] atom_mem [MAX_ATOMS];
   logic [31:0] hist_mem [HIST_BINS];

   logic [2:0] side_log2_ff;
   logic [CW-1:0] atom_count_ff;

   state_type state_ff, state_in;
   logic [HW:0] clr_ff, clr_in;
   logic [AW-1:0] i_ff, i_in, j_ff, j_in;
   logic [11:0] site_a_ff, site_b_ff;
   logic signed [DW-1:0] t_ff, dy_ff;
   logic [2:0] sel_ff;
   logic [1:0] img_ff, img_in;
   logic [DW-1:0] s_ff, s_in;
   logic [PW-1:0] rem_ff, rem_in;
   logic [PW-1:0] root_ff, root_in;
   logic [PW-1:0] bit_ff, bit_in;
   logic [HW:0] bin_ff;
   logic bin_oor_ff;
   logic [31:0] hist_rd_ff;
   logic rerr_ff, rerr_in, sat_ff, sat_in;
   rsp_type rsp_ff, rsp_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [1:0] op_ff;
   logic [12:0] rsel_ff;

   // effective side log2
   logic [2:0] l_eff;
   always_comb begin
      l_eff = side_log2_ff;
      if (l_eff < 3'd1) l_eff = 3'd1;
      for (int k = 0; k < 8; k++)
         if (l_eff > 3'd1 && (32'd1 << l_eff) > 32'(MAX_SIDE)) l_eff = l_eff - 3'd1;
   end

   logic [CW-1:0] na;
   assign na = (atom_count_ff > CW'(MAX_ATOMS)) ? CW'(MAX_ATOMS) : atom_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         side_log2_ff  <= 3'd6;
         atom_count_ff <= CW'(1);
      end else if (csr_write_enable) begin
         if (csr_index == CSR_SIDE_LOG2) side_log2_ff <= csr_write_data[2:0];
         else atom_count_ff <= (csr_write_data > 9'(MAX_ATOMS)) ? CW'(MAX_ATOMS)
                                                                 : CW'(csr_write_data);
      end
   end

   // pair decode: row and column of both sites
   logic [SW-1:0] smask;
   logic [SLW-1:0] cmask;
   logic [SW-1:0] a_m, b_m;
   logic signed [9:0] ra, rb, ca, cb, dy_w, dc_w;
   always_comb begin
      smask = SW'((32'd1 << (2 * l_eff)) - 32'd1);
      cmask = SLW'((32'd1 << l_eff) - 32'd1);
      a_m = site_a_ff[SW-1:0] & smask;
      b_m = site_b_ff[SW-1:0] & smask;
      ra = 10'(a_m >> l_eff);
      rb = 10'(b_m >> l_eff);
      ca = 10'(a_m[SLW-1:0] & cmask);
      cb = 10'(b_m[SLW-1:0] & cmask);
      dy_w = rb - ra;
      dc_w = cb - ca;
   end

   // image offsets; sel picks which case of sign pattern
   // img 0 is the direct distance, img k the k-th periodic image
   logic signed [DW-1:0] d, off_t [3], off_y [3], cand_t, cand_y;
   logic [DW-1:0] cand_s;
   logic [1:0] n_img;
   always_comb begin
      d = DW'(32'd1 << l_eff);
      for (int k = 0; k < 3; k++) begin
         off_t[k] = '0;
         off_y[k] = '0;
      end
      n_img = 2'd1;
      unique case (sel_ff)
         3'd0: begin n_img = 2'd3;
            off_t[0] = -d; off_y[0] = -d;
            off_t[1] = DW'(-(3*d-1)); off_y[1] = DW'(-(d-1));
            off_t[2] = DW'(-(2*d-1)); off_y[2] = DW'(1); end
         3'd1: begin n_img = 2'd3;
            off_t[0] = d; off_y[0] = d;
            off_t[1] = DW'(-(2*d-1)); off_y[1] = DW'(1);
            off_t[2] = DW'(-(d-1)); off_y[2] = DW'(d + 1); end
         3'd2: begin off_t[0] = DW'(-(2*d-1)); off_y[0] = DW'(1); end
         3'd3: begin n_img = 2'd3;
            off_t[0] = -d; off_y[0] = -d;
            off_t[1] = DW'(2*d-1); off_y[1] = DW'(-1);
            off_t[2] = DW'(d-1); off_y[2] = DW'(-(d+1)); end
         3'd4: begin n_img = 2'd3;
            off_t[0] = d; off_y[0] = d;
            off_t[1] = DW'(3*d-1); off_y[1] = DW'(d-1);
            off_t[2] = DW'(2*d-1); off_y[2] = DW'(-1); end
         3'd5: begin off_t[0] = DW'(2*d-1); off_y[0] = DW'(-1); end
         3'd6: begin off_t[0] = -d; off_y[0] = -d; end
         default: begin off_t[0] = d; off_y[0] = d; end
      endcase
      cand_t = t_ff;
      cand_y = dy_ff;
      unique case (img_ff)
         2'd1: begin cand_t = t_ff + off_t[0]; cand_y = dy_ff + off_y[0]; end
         2'd2: begin cand_t = t_ff + off_t[1]; cand_y = dy_ff + off_y[1]; end
         2'd3: begin cand_t = t_ff + off_t[2]; cand_y = dy_ff + off_y[2]; end
         default: ;
      endcase
      cand_s = DW'(cand_t * cand_t + 3 * cand_y * cand_y);
   end

   logic [2:0] sel_w;
   always_comb begin
      if (dc_w > 0) sel_w = (dy_w > 0) ? 3'd0 : (dy_w < -1) ? 3'd1 : 3'd2;
      else if (dc_w < 0) sel_w = (dy_w > 1) ? 3'd3 : (dy_w < 0) ? 3'd4 : 3'd5;
      else sel_w = (dy_w > 0) ? 3'd6 : 3'd7;
   end

   // bit-serial square root; each step shifts the trial bit down by two operand bit positions and yields one root bit
   logic [PW-1:0] trial;
   always_comb begin
      trial = root_ff + bit_ff;
      rem_in = rem_ff;
      root_in = root_ff;
      bit_in = bit_ff >> 2;
      if (rem_ff >= trial) begin
         rem_in = rem_ff - trial;
         root_in = (root_ff >> 1) + bit_ff;
      end else begin
         root_in = root_ff >> 1;
      end
   end

   logic [RW:0] bin_full;
   assign bin_full = (RW+1)'((root_ff + PW'(1)) >> 1);

   logic last_j, last_i;
   assign last_j = (CW'(j_ff) == na - CW'(1));
   assign last_i = (CW'(i_ff) == na - CW'(1));

   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      i_in = i_ff;
      j_in = j_ff;
      img_in = img_ff;
      s_in = s_ff;
      rerr_in = rerr_ff;
      sat_in = sat_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == (HW+1)'(HIST_BINS - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               rsp_in = '0;
               rerr_in = 1'b0;
               sat_in = 1'b0;
               i_in = '0;
               j_in = AW'(1);
               if (req_data.opcode == OP_ACCUM)
                  state_in = (na < CW'(2)) ? ST_RESP : ST_PAIR_RD;
               else if (req_data.opcode == OP_READ) state_in = ST_READ_WAIT;
               else state_in = ST_RESP;
            end
         end
         ST_PAIR_RD: state_in = ST_PAIR_DIST;
         ST_PAIR_DIST: begin
            img_in = 2'd0;
            state_in = ST_MIN;
         end
         ST_MIN: begin
            img_in = img_ff + 2'd1;
            if (img_ff == 2'd0 || cand_s < s_ff) s_in = cand_s;
            if (img_ff == n_img) state_in = ST_MUL;
         end
         ST_MUL: state_in = ST_SQRT;
         ST_SQRT: if (bit_ff == '0) state_in = ST_HIST_RD;
         ST_HIST_RD: state_in = ST_HIST_WR;
         ST_HIST_WR: begin
            if (bin_oor_ff) rerr_in = 1'b1;
            else if (hist_rd_ff >= 32'hFFFF_FFFE) sat_in = 1'b1;
            // advance to next ordered pair, skipping i == j
            state_in = ST_PAIR_RD;
            if (last_j || (CW'(j_ff) == na - CW'(2) && CW'(i_ff) == na - CW'(1))) begin
               if (last_i) state_in = ST_RESP;
               i_in = i_ff + 1'b1;
               j_in = (i_ff + 1'b1 == '0) ? AW'(1) : '0;
            end else begin
               j_in = (j_ff + 1'b1 == i_ff) ? j_ff + AW'(2) : j_ff + 1'b1;
            end
         end
         ST_READ_WAIT: begin
            rsp_in.bin_count = (32'(rsel_ff) < 32'(HIST_BINS)) ? hist_rd_ff : '0;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (op_ff == OP_ACCUM) begin
               rsp_in.range_error = rerr_ff;
               rsp_in.saturated = sat_ff;
            end
            rsp_valid_in = 1'b1;
            if (rsp_valid_ff && rsp_ready) begin
               rsp_valid_in = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff <= i_in;
      j_ff <= j_in;
      img_ff <= img_in;
      s_ff <= s_in;
      rerr_ff <= rerr_in;
      sat_ff <= sat_in;
      rsp_ff <= rsp_in;
      if (state_ff == ST_IDLE && req_valid) begin
         op_ff <= req_data.opcode;
         rsel_ff <= req_data.bin_select;
      end
      if (state_ff == ST_PAIR_DIST) begin
         t_ff <= DW'(2 * dc_w + dy_w);
         dy_ff <= DW'(dy_w);
         sel_ff <= sel_w;
      end
      if (state_ff == ST_MUL) begin
         rem_ff <= PW'(K2 * 64'(s_ff));
         root_ff <= '0;
         bit_ff <= PW'(1) << (PW - 2);
      end else if (state_ff == ST_SQRT) begin
         rem_ff <= rem_in;
         root_ff <= root_in;
         bit_ff <= bit_in;
      end
      if (state_ff == ST_SQRT && bit_ff == '0) begin
         bin_oor_ff <= (32'(bin_full) >= 32'(HIST_BINS));
         bin_ff <= (HW+1)'(bin_full);
      end
   end

   // atom site memory
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_valid && req_data.opcode == OP_WRITE
          && 32'(req_data.atom_slot) < 32'(MAX_ATOMS))
         atom_mem[req_data.atom_slot[AW-1:0]] <= req_data.site_index;
      if (state_ff == ST_PAIR_RD) site_a_ff <= atom_mem[i_ff];
   end
   always_ff @(posedge clock) begin
      if (state_ff == ST_PAIR_RD) site_b_ff <= atom_mem[j_ff];
   end

   // histogram memory: clear sweep, read, increment write
   always_ff @(posedge clock) begin
      if (state_ff == ST_CLEAR) hist_mem[clr_ff[HW-1:0]] <= '0;
      else if (state_ff == ST_HIST_WR && !bin_oor_ff && hist_rd_ff != 32'hFFFF_FFFF)
         hist_mem[bin_ff[HW-1:0]] <= hist_rd_ff + 32'd1;
      if (state_ff == ST_HIST_RD) hist_rd_ff <= hist_mem[bin_ff[HW-1:0]];
      else if (state_ff == ST_IDLE) hist_rd_ff <= hist_mem[req_data.bin_select[HW-1:0]];
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   // a response is only raised in the response state
   a_rsp_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (state_ff == ST_RESP))
      else $error("rsp_valid outside response state");
   // no command taken during clear sweep
   a_clear_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !req_ready)
      else $error("ready during clear");
   // flags only for accumulate
   a_flags: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && op_ff != OP_ACCUM) |-> !rsp_data.range_error && !rsp_data.saturated)
      else $error("flags on non-accumulate response");

endmodule

// File: sim/testbench.sv
// testbench for the lattice pair histogram: directed and random commands, scoreboard check
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import hlph_pkg::*;

   localparam logic [1:0] OP_SPARE = 2'd3;
   localparam int STALL_LIMIT = 40000;
   localparam int FILLED_SLOTS = 8;

   class pair_hist_scoreboard;
      rsp_type     pending_rsp[$];
      int unsigned hist[HIST_BINS_DEF];
      logic [11:0] sites[MAX_ATOMS_DEF];
      int unsigned side_cfg = 6;
      int unsigned count_cfg = 1;
      int          errors = 0;

      function automatic longint unsigned sqrt_floor(longint unsigned n);
         longint unsigned r, b;
         r = 0;
         b = 64'd1 << 62;
         while (b > n) b = b >> 2;
         while (b != 0) begin
            if (n >= r + b) begin
               n = n - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
         return r;
      endfunction

      // skewed squared distance lowered over sign-selected periodic images
      function automatic int image_sq_dist(int unsigned a, int unsigned b, int unsigned l);
         int d, dy, dc, t, n, s, ns, tm, ym;
         int m[8];
         int off[6];
         d = 1 << l;
         dy = int'(b >> l) - int'(a >> l);
         dc = int'(b & (d - 1)) - int'(a & (d - 1));
         t = 2 * dc + dy;
         m[0] = d;         m[1] = 2 * d;
         m[2] = 3 * d - 1; m[3] = 2 * d - 2;
         m[4] = 2 * d - 1; m[5] = -2;
         m[6] = d - 1;     m[7] = -2 * d - 2;
         if (dc > 0) begin
            if (dy > 0) begin
               n = 3;
               off = '{-m[0], -m[1], -m[2], -m[3], -m[4], -m[5]};
            end else if (dy < -1) begin
               n = 3;
               off = '{m[0], m[1], -m[4], -m[5], -m[6], -m[7]};
            end else begin
               n = 1;
               off = '{-m[4], -m[5], 0, 0, 0, 0};
            end
         end else if (dc < 0) begin
            if (dy > 1) begin
               n = 3;
               off = '{-m[0], -m[1], m[4], m[5], m[6], m[7]};
            end else if (dy < 0) begin
               n = 3;
               off = '{m[0], m[1], m[2], m[3], m[4], m[5]};
            end else begin
               n = 1;
               off = '{m[4], m[5], 0, 0, 0, 0};
            end
         end else begin
            n = 1;
            if (dy > 0) off = '{-m[0], -m[1], 0, 0, 0, 0};
            else off = '{m[0], m[1], 0, 0, 0, 0};
         end
         s = t * t + 3 * dy * dy;
         for (int k = 0; k < n; k++) begin
            tm = t + off[2 * k];
            ym = dy + off[2 * k + 1] / 2;
            ns = tm * tm + 3 * ym * ym;
            if (ns < s) s = ns;
         end
         return s;
      endfunction

      function void write_csr(logic idx, logic [8:0] value);
         if (idx == CSR_SIDE_LOG2) side_cfg = value[2:0];
         else count_cfg = value;
      endfunction

      function void note_command(req_type cmd);
         rsp_type r;
         int unsigned l, na, smask, s;
         longint unsigned b;
         r = '0;
         case (cmd.opcode)
            OP_WRITE: sites[cmd.atom_slot] = cmd.site_index;
            OP_ACCUM: begin
               l = (side_cfg < 1) ? 1 : side_cfg;
               while (l > 1 && (1 << l) > MAX_SIDE_DEF) l--;
               smask = (1 << (2 * l)) - 1;
               na = (count_cfg > MAX_ATOMS_DEF) ? MAX_ATOMS_DEF : count_cfg;
               for (int i = 0; i < na; i++)
                  for (int j = 0; j < na; j++) begin
                     if (i == j) continue;
                     s = image_sq_dist(sites[i] & smask, sites[j] & smask, l);
                     b = (sqrt_floor(longint'(BINS_PER_UNIT_DEF) * BINS_PER_UNIT_DEF * s)
                          + 1) >> 1;
                     if (b >= HIST_BINS_DEF) begin
                        r.range_error = 1'b1;
                        continue;
                     end
                     if (hist[b] != 32'hFFFF_FFFF) hist[b]++;
                     if (hist[b] == 32'hFFFF_FFFF) r.saturated = 1'b1;
                  end
            end
            OP_READ: if (cmd.bin_select < HIST_BINS_DEF) r.bin_count = hist[cmd.bin_select];
            default: ;
         endcase
         pending_rsp.push_back(r);
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected response %h", $time, got);
            errors++;
            return;
         end
         want = pending_rsp.pop_front();
         if (got.bin_count !== want.bin_count) begin
            $display("%0t: bin_count expected %0d actual %0d", $time, want.bin_count,
                     got.bin_count);
            errors++;
         end
         if (got.range_error !== want.range_error) begin
            $display("%0t: range_error expected %b actual %b", $time, want.range_error,
                     got.range_error);
            errors++;
         end
         if (got.saturated !== want.saturated) begin
            $display("%0t: saturated expected %b actual %b", $time, want.saturated,
                     got.saturated);
            errors++;
         end
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   req_type    req_data = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   rsp_type    rsp_data;
   logic       csr_write_enable = 1'b0;
   logic       csr_index = 1'b0;
   logic [8:0] csr_write_data = '0;

   pair_hist_scoreboard hist_sb = new();
   bit no_idle = 0;
   bit hold_off_request = 0;
   int stall_cycles = 0;

   hex_lattice_pair_histogram_top uut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("testbench: errors");
         $finish;
      end
   end

   // response side: random back-pressure plus one long hold-off on request
   initial begin
      int gap;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         gap = no_idle ? 0 : $urandom_range(0, 6);
         if (hold_off_request) begin
            hold_off_request = 0;
            gap = 300;
         end
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         hist_sb.check_response(rsp_data);
      end
   end

   task automatic send_command(logic [1:0] op, logic [7:0] slot, logic [11:0] site,
                               logic [12:0] sel);
      req_type cmd;
      int gap;
      cmd = '{opcode: op, atom_slot: slot, site_index: site, bin_select: sel};
      req_data <= cmd;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      hist_sb.note_command(cmd);
      gap = no_idle ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (hist_sb.pending_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [8:0] value);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(posedge clock);
      hist_sb.write_csr(idx, value);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      int sel_count;
      int op_pick;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: fill the slots used by accumulate passes, extreme sites
      send_command(OP_ACCUM, 8'd0, 12'd0, 13'd0);   // one atom: no pairs
      send_command(OP_WRITE, 8'd0, 12'd0, 13'd0);
      send_command(OP_WRITE, 8'd1, 12'hFFF, 13'd0);
      send_command(OP_WRITE, 8'd2, 12'hAAA, 13'd0);
      send_command(OP_WRITE, 8'd3, 12'h555, 13'd0);
      send_command(OP_WRITE, 8'd4, 12'd63, 13'd0);
      send_command(OP_WRITE, 8'd5, 12'd64, 13'd0);
      send_command(OP_WRITE, 8'd6, 12'd1, 13'd0);
      send_command(OP_WRITE, 8'd7, 12'hF3F, 13'd0);
      send_command(OP_WRITE, 8'd255, 12'hFFF, 13'h1FFF);
      send_command(OP_SPARE, 8'hFF, 12'hFFF, 13'h1FFF);
      drain();
      write_csr(CSR_ATOM_COUNT, 9'd0);
      send_command(OP_ACCUM, 8'd0, 12'd0, 13'd0);
      drain();
      write_csr(CSR_ATOM_COUNT, 9'd8);
      send_command(OP_ACCUM, 8'd0, 12'd0, 13'd0);
      drain();
      write_csr(CSR_SIDE_LOG2, 9'd0);
      send_command(OP_ACCUM, 8'd0, 12'd0, 13'd0);
      drain();
      write_csr(CSR_SIDE_LOG2, 9'd7);
      write_csr(CSR_ATOM_COUNT, 9'd2);
      send_command(OP_ACCUM, 8'd0, 12'd0, 13'd0);
      send_command(OP_READ, 8'd0, 12'd0, 13'd0);
      send_command(OP_READ, 8'd0, 12'd0, 13'd8191);
      drain();
      write_csr(CSR_ATOM_COUNT, 9'd256);
      send_command(OP_READ, 8'd0, 12'd0, 13'd100);

      // receiver holds off while commands keep coming
      hold_off_request = 1;
      for (int k = 0; k < 4; k++)
         send_command(OP_READ, 8'd0, 12'd0, 13'($urandom_range(0, 4000)));
      drain();

      // random phases, each under a fresh register setting
      for (int phase = 0; phase < 8; phase++) begin
         no_idle = (phase == 3 || phase == 6);
         write_csr(CSR_SIDE_LOG2, 9'($urandom_range(0, 7)));
         write_csr(CSR_ATOM_COUNT,
                   (phase == 5) ? 9'd256 : 9'($urandom_range(0, FILLED_SLOTS)));
         for (int k = 0; k < 10; k++) begin
            op_pick = $urandom_range(0, 9);
            sel_count = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8191)
                                                    : $urandom_range(0, 4000);
            if (op_pick < 4)
               send_command(OP_WRITE, 8'($urandom_range(0, 255)),
                            12'($urandom_range(0, 4095)), 13'($urandom_range(0, 8191)));
            else if (op_pick < 6 && hist_sb.count_cfg <= FILLED_SLOTS)
               send_command(OP_ACCUM, 8'($urandom_range(0, 255)),
                            12'($urandom_range(0, 4095)), 13'($urandom_range(0, 8191)));
            else if (op_pick == 9)
               send_command(OP_SPARE, 8'($urandom_range(0, 255)),
                            12'($urandom_range(0, 4095)), 13'($urandom_range(0, 8191)));
            else
               send_command(OP_READ, 8'($urandom_range(0, 255)),
                            12'($urandom_range(0, 4095)), 13'(sel_count));
         end
         drain();
      end

      repeat (50) @(posedge clock);
      if (hist_sb.errors == 0 && hist_sb.pending_rsp.size() == 0) $display("testbench: clean");
      else $display("testbench: errors");
      $finish;
   end
endmodule

// File: sim.f
rtl/core/hlph_pkg.sv
rtl/core/hex_lattice_pair_histogram_top.sv
sim/testbench.sv
